// ===== hw/rtl/dvrt_pkg.sv =====
// Shared types and constants of the distance-vector route table.
package dvrt_pkg;

  localparam int unsigned Nodes = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned CostW = 24;
  localparam int unsigned TickW = 16;
  localparam logic [CostW-1:0] Unreach = '1;

  typedef enum logic [2:0] {
    ModeAdd = 3'd0,
    ModeCost = 3'd1,
    ModeTick = 3'd2,
    ModeAdvert = 3'd3,
    ModeFwd = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    StDone = 2'd0,
    StLocal = 2'd1,
    StFwd = 2'd2,
    StUnreach = 2'd3
  } status_e;

  // Per-entry row state.
  typedef struct packed {
    logic [CostW-1:0] path_cost;
    logic [IdxW-1:0]  hop_index;
    logic             hop_valid;
    logic             is_neighbor;
    logic [CostW-1:0] direct_cost;
    logic             heard_from;
    logic [TickW-1:0] last_heard;
    logic             declared_down;
  } row_t;

  // Command handed from one cell to the next during a sweep.
  typedef struct packed {
    logic             valid;
    logic             tick;      // tick pass, phase one: mark downs
    logic             purge;     // tick pass, phase two: drop routes via downs
    logic             restore;   // advert first entry: restore direct routes
    logic [Nodes-1:0] down_set;  // neighbours declared down in phase one
    logic [TickW-1:0] tick_count;
    logic [7:0]       timeout;
  } sweep_t;

endpackage

// ===== hw/rtl/dvrt_cell.sv =====
// One table cell: holds a row and applies the sweep command passing through.
module dvrt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dvrt_pkg::IdxW-1:0]     my_idx_i,
  input  dvrt_pkg::sweep_t              sweep_i,
  output dvrt_pkg::sweep_t              sweep_o,
  input  logic                          wr_en_i,
  input  dvrt_pkg::row_t                wr_row_i,
  output dvrt_pkg::row_t                row_o
);

  dvrt_pkg::row_t   row_q, row_d;
  dvrt_pkg::sweep_t sweep_q, sweep_d;
  logic [dvrt_pkg::TickW-1:0] age;

  always_comb begin
    row_d   = row_q;
    sweep_d = sweep_i;
    age     = sweep_i.tick_count - row_q.last_heard;
    if (wr_en_i) begin
      row_d = wr_row_i;
    end else if (sweep_i.valid) begin
      if (sweep_i.tick && row_q.is_neighbor && row_q.heard_from && !row_q.declared_down &&
          (age >= {8'd0, sweep_i.timeout})) begin
        row_d.direct_cost   = dvrt_pkg::Unreach;
        row_d.declared_down = 1'b1;
        sweep_d.down_set[my_idx_i] = 1'b1;
      end
      if (sweep_i.purge && row_q.hop_valid && sweep_i.down_set[row_q.hop_index]) begin
        row_d.hop_valid = 1'b0;
        row_d.hop_index = '0;
        row_d.path_cost = dvrt_pkg::Unreach;
      end
      if (sweep_i.restore && row_q.is_neighbor && !row_q.declared_down &&
          (row_q.path_cost > row_q.direct_cost)) begin
        row_d.path_cost = row_q.direct_cost;
        row_d.hop_index = my_idx_i;
        row_d.hop_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q.path_cost     <= dvrt_pkg::Unreach;
      row_q.hop_index     <= '0;
      row_q.hop_valid     <= 1'b0;
      row_q.is_neighbor   <= 1'b0;
      row_q.direct_cost   <= dvrt_pkg::Unreach;
      row_q.heard_from    <= 1'b0;
      row_q.last_heard    <= '0;
      row_q.declared_down <= 1'b0;
      sweep_q             <= '0;
    end else begin
      row_q   <= row_d;
      sweep_q <= sweep_d;
    end
  end

  assign row_o   = row_q;
  assign sweep_o = sweep_q;

endmodule

// ===== hw/rtl/distance_vector_route_table.sv =====
// Top level of the distance-vector route table: control, cell chain and APB port.
//
//  Channel | Direction | Handshake        | Payload
//  in      | input     | in_valid/stall   | mode, node_a, node_b, link_cost, first_entry
//  out     | output    | out_valid/stall  | status, fwd_hop, route_cost, down_mask
//  apb     | input     | psel/penable     | own_id at 0x0, timeout_ticks at 0x4
//
// One item is worked on at a time. Add, cost change, forward and unknown modes
// go from the execution state straight to the output register; an ordinary
// advertisement entry executes, then marks the sender heard and relaxes the destination row.
// A tick executes and then makes two passes along the chain of sixteen cells:
// the first marks silent neighbours down, the second drops routes through them.
// A first advertisement entry executes, makes one pass, then relaxes.
// All state is cleared at once by reset. The result waits in an output register
// while the output is stalled; the next item is taken once that transfer is done.
module distance_vector_route_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [3:0]  node_a_i,
  input  logic [3:0]  node_b_i,
  input  logic [15:0] link_cost_i,
  input  logic        first_entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  fwd_hop_o,
  output logic [23:0] route_cost_o,
  output logic [15:0] down_mask_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N = dvrt_pkg::Nodes;
  localparam int unsigned CntW = $clog2(N + 2);

  typedef enum logic [2:0] {
    SIdle, SExec, SSweep1, SSweep2, SRelax, SOut
  } state_e;

  state_e state_q;
  logic [3:0]  own_id_q;
  logic [7:0]  timeout_q;
  logic [15:0] tick_q;
  logic [2:0]  mode_q;
  logic [3:0]  a_q, b_q;
  logic [15:0] w_q;
  logic        first_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]  status_q;
  logic [3:0]  hop_q;
  logic [23:0] cost_q;
  logic [15:0] mask_q;

  dvrt_pkg::sweep_t chain [N+1];
  dvrt_pkg::row_t   rows  [N];
  logic [N-1:0]     wr_en;
  dvrt_pkg::row_t   wr_row [N];

  assign chain[0].valid      = (state_q == SSweep1 || state_q == SSweep2) && (cnt_q == '0);
  assign chain[0].tick       = (state_q == SSweep1) && (mode_q == dvrt_pkg::ModeTick);
  assign chain[0].purge      = (state_q == SSweep2);
  assign chain[0].restore    = (state_q == SSweep1) && (mode_q == dvrt_pkg::ModeAdvert);
  assign chain[0].down_set   = mask_q;
  assign chain[0].tick_count = tick_q;
  assign chain[0].timeout    = timeout_q;

  for (genvar g = 0; g < N; g++) begin : g_cell
    dvrt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (4'(g)),
      .sweep_i  (chain[g]),
      .sweep_o  (chain[g+1]),
      .wr_en_i  (wr_en[g]),
      .wr_row_i (wr_row[g]),
      .row_o    (rows[g])
    );
  end

  // Row updates for add and cost change (one row) and relax (source and destination rows).
  logic [3:0] tgt;
  logic [23:0] sum;
  logic [24:0] sum_w;
  dvrt_pkg::row_t ra, rb, rt;
  always_comb begin
    tgt   = (a_q == own_id_q) ? b_q : a_q;
    ra    = rows[a_q];
    rb    = rows[b_q];
    rt    = rows[tgt];
    sum_w = {1'b0, ra.path_cost} + {9'd0, w_q};
    sum   = (sum_w >= {1'b0, dvrt_pkg::Unreach}) ? dvrt_pkg::Unreach : sum_w[23:0];
    for (int i = 0; i < N; i++) begin
      wr_en[i]  = 1'b0;
      wr_row[i] = rows[i];
    end
    if (state_q == SExec && mode_q == dvrt_pkg::ModeAdd && a_q != own_id_q) begin
      wr_en[a_q] = 1'b1;
      wr_row[a_q].path_cost     = {8'd0, w_q};
      wr_row[a_q].hop_index     = a_q;
      wr_row[a_q].hop_valid     = 1'b1;
      wr_row[a_q].is_neighbor   = 1'b1;
      wr_row[a_q].direct_cost   = {8'd0, w_q};
      wr_row[a_q].heard_from    = 1'b0;
      wr_row[a_q].declared_down = 1'b0;
    end else if (state_q == SExec && mode_q == dvrt_pkg::ModeCost && tgt != own_id_q) begin
      wr_en[tgt] = 1'b1;
      wr_row[tgt].direct_cost = {8'd0, w_q};
      if (rt.hop_valid && rt.hop_index == tgt) begin
        wr_row[tgt].path_cost = {8'd0, w_q};
      end else if (rt.path_cost > {8'd0, w_q}) begin
        wr_row[tgt].path_cost = {8'd0, w_q};
        wr_row[tgt].hop_index = tgt;
        wr_row[tgt].hop_valid = 1'b1;
      end
    end else if (state_q == SRelax) begin
      wr_en[a_q] = 1'b1;
      wr_row[a_q].heard_from = 1'b1;
      wr_row[a_q].last_heard = tick_q;
      if (b_q != own_id_q) begin
        wr_en[b_q] = 1'b1;
        if (b_q == a_q) begin
          wr_row[b_q].heard_from = 1'b1;
          wr_row[b_q].last_heard = tick_q;
        end
        if ((rb.hop_valid && rb.hop_index == a_q) || rb.path_cost > sum) begin
          wr_row[b_q].path_cost = sum;
        end
        if (!(rb.hop_valid && rb.hop_index == a_q) && rb.path_cost > sum) begin
          wr_row[b_q].hop_index = ra.hop_index;
          wr_row[b_q].hop_valid = ra.hop_valid;
        end
      end
    end
  end

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);
  assign status_o     = status_q;
  assign fwd_hop_o    = hop_q;
  assign route_cost_o = cost_q;
  assign down_mask_o  = mask_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, own_id_q} : {24'd0, timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      own_id_q  <= '0;
      timeout_q <= 8'd3;
      tick_q    <= '0;
      cnt_q     <= '0;
      mask_q    <= '0;
      status_q  <= '0;
      hop_q     <= '0;
      cost_q    <= '0;
      mode_q    <= '0;
      a_q       <= '0;
      b_q       <= '0;
      w_q       <= '0;
      first_q   <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == 1'b0) own_id_q <= pwdata[3:0];
        else timeout_q <= pwdata[7:0];
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            mode_q   <= mode_i;
            a_q      <= node_a_i;
            b_q      <= node_b_i;
            w_q      <= link_cost_i;
            first_q  <= first_entry_i;
            status_q <= dvrt_pkg::StDone;
            hop_q    <= '0;
            cost_q   <= '0;
            mask_q   <= '0;
            cnt_q    <= '0;
            state_q  <= SExec;
          end
        end
        SExec: begin
          case (mode_q)
            dvrt_pkg::ModeTick: begin
              tick_q  <= tick_q + 16'd1;
              state_q <= SSweep1;
            end
            dvrt_pkg::ModeAdvert: begin
              state_q <= first_q ? SSweep1 : SRelax;
            end
            dvrt_pkg::ModeFwd: begin
              if (b_q == own_id_q) begin
                status_q <= dvrt_pkg::StLocal;
              end else if (rb.path_cost != dvrt_pkg::Unreach) begin
                status_q <= dvrt_pkg::StFwd;
                hop_q    <= rb.hop_index;
                cost_q   <= rb.path_cost;
              end else begin
                status_q <= dvrt_pkg::StUnreach;
                cost_q   <= dvrt_pkg::Unreach;
              end
              state_q <= SOut;
            end
            default: state_q <= SOut;
          endcase
        end
        SSweep1: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(N)) begin
            cnt_q <= '0;
            if (mode_q == dvrt_pkg::ModeTick) begin
              mask_q  <= chain[N].down_set;
              state_q <= SSweep2;
            end else begin
              state_q <= SRelax;
            end
          end
        end
        SSweep2: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(N)) begin
            state_q <= SOut;
          end
        end
        SRelax: state_q <= SOut;
        SOut: begin
          if (!out_stall_i) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) |-> in_stall_o) else $error("input taken while a result waits");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_q)))
    else $error("result changed while stalled");
  a_mask_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q != dvrt_pkg::ModeTick) |-> (mask_q == '0))
    else $error("down mask outside a tick");
`endif

endmodule
